>>> design/sws_pkg.sv
// Shared types, codes and constants of the sliding window sender.
`timescale 1ns / 1ps
`default_nettype none

package sws_pkg;

    // Default window size in packets.
    localparam int WINDOW_DEF = 8;

    // Repeats of the ACK just below the window that trigger a resend.
    localparam int DUP_LIMIT = 2;

    // Timeout run length above which the transfer aborts.
    localparam int TIMEOUT_LIMIT = 3;

    localparam int SEQ_W = 32;
    localparam int PCNT_W = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index of packet_count, taken from paddr[2].
    localparam logic REG_PACKET_COUNT = 1'b0;

    // Input operation codes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_PACKET = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic             syn_bit;
        logic             ack_bit;
        logic             fin_bit;
        logic [SEQ_W-1:0] ack_number;
        logic [SEQ_W-1:0] seq_number;
    } t_in;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SEQ_W-1:0] send_seq;
        logic [SEQ_W-1:0] send_ack;
        logic             last;
    } t_out;

    // Commands from the controller to the datapath, one strobe per step.
    typedef struct packed {
        logic load_in;
        logic eval;
        logic limit;
        logic send;
        logic stat;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ev_limit;
        logic ev_stat;
        logic nonempty;
        logic at_end;
        logic stat_pend;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> design/sws_ctrl.sv
// Controller state machine of the sliding window sender.
`timescale 1ns / 1ps
`default_nettype none

module sws_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire sws_pkg::t_sts i_sts,
    output sws_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_LIMIT = 5'b00100,
        S_SEND  = 5'b01000,
        S_STAT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.ev_stat) begin
                    n_state = S_STAT;
                end else if (i_sts.ev_limit) begin
                    n_state = S_LIMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LIMIT: begin
                o_cmd.limit = 1'b1;
                if (i_sts.nonempty) begin
                    n_state = S_SEND;
                end else if (i_sts.stat_pend) begin
                    n_state = S_STAT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.send = 1'b1;
                    if (i_sts.at_end) begin
                        n_state = i_sts.stat_pend ? S_STAT : S_IDLE;
                    end
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.stat = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    // A send or status step only happens when the output register can take it.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.send || o_cmd.stat) |-> i_sts.out_free)
        else $error("result loaded while output register is occupied");

    // Every accepted transaction is evaluated in the following cycle.
    a_eval_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> o_cmd.eval)
        else $error("accepted transaction was not evaluated");

    // The last send of a range returns to idle unless a status result follows.
    a_send_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.send && i_sts.at_end && !i_sts.stat_pend) |=> !o_in_stall)
        else $error("controller did not return to idle after final send");
`endif

endmodule

`default_nettype wire

>>> design/sws_datapath.sv
// Datapath of the sliding window sender: window state, send cursor, result register.
`timescale 1ns / 1ps
`default_nettype none

module sws_datapath #(
    parameter int WINDOW = sws_pkg::WINDOW_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sws_pkg::t_in                i_in_data,
    input  wire logic [sws_pkg::PCNT_W-1:0]  i_pkt_count,
    input  wire sws_pkg::t_cmd               i_cmd,
    output sws_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    output sws_pkg::t_out                    o_out_data,
    input  wire logic                        i_out_stall
);

    localparam int SW = sws_pkg::SEQ_W;
    localparam logic [SW:0] WIN_SPAN = (SW+1)'(WINDOW - 1);
    localparam logic [SW-1:0] SEQ_MAX = '1;

    sws_pkg::t_in  r_in;
    logic [SW-1:0] r_head;
    logic [SW-1:0] r_end;
    logic [SW-1:0] r_final;
    logic [SW-1:0] r_peer;
    logic [1:0]    r_dup;
    logic [2:0]    r_to_cnt;
    logic          r_active;
    logic [SW-1:0] r_cur;
    logic [SW-1:0] r_to;
    logic          r_supp;
    logic          r_stat_pend;
    logic [1:0]    r_stat_kind;
    logic          r_out_valid;
    sws_pkg::t_out r_out;

    // Evaluation of the latched transaction against the window state.
    logic [SW-1:0] sum_head;
    logic [SW-1:0] sum_fin;
    logic          is_start;
    logic          is_packet;
    logic          is_timeout;
    logic          plain_ack;
    logic          in_win;
    logic          is_dup;
    logic [1:0]    dup_n;
    logic          dup_fire;
    logic          start_empty;
    logic          slide_done;
    logic          abort_now;
    logic          ev_limit;
    logic          ev_stat;

    always_comb begin
        sum_head = r_in.ack_number + 32'd1;
        sum_fin = r_in.ack_number + SW'(i_pkt_count);
        is_start = (r_in.op == sws_pkg::OP_START);
        is_packet = (r_in.op == sws_pkg::OP_PACKET) && r_active;
        is_timeout = (r_in.op == sws_pkg::OP_TIMEOUT) && r_active;
        plain_ack = !r_in.syn_bit && r_in.ack_bit && !r_in.fin_bit;
        in_win = (r_in.ack_number >= r_head) && (r_in.ack_number <= r_end);
        is_dup = (r_in.ack_number == r_head - 32'd1);
        dup_n = r_dup + 2'd1;
        dup_fire = (dup_n >= 2'(sws_pkg::DUP_LIMIT));
        start_empty = (i_pkt_count == '0) || (sum_head > sum_fin);
        slide_done = (r_in.ack_number == SEQ_MAX) || (sum_head > r_final);
        abort_now = (r_to_cnt > 3'(sws_pkg::TIMEOUT_LIMIT));
        ev_limit = 1'b0;
        ev_stat = 1'b0;
        if (is_start) begin
            ev_stat = start_empty;
            ev_limit = !start_empty;
        end else if (is_packet && plain_ack) begin
            if (in_win) begin
                ev_stat = slide_done;
                ev_limit = !slide_done;
            end else if (is_dup) begin
                ev_limit = dup_fire;
            end
        end else if (is_timeout) begin
            ev_limit = 1'b1;
        end
    end

    // Window limit: head plus span, clipped to the final sequence number.
    logic [SW:0]   head_span;
    logic          clip;
    logic [SW-1:0] lim;
    logic          cur_ok;

    always_comb begin
        head_span = {1'b0, r_head} + WIN_SPAN;
        clip = (head_span > {1'b0, r_final});
        lim = clip ? r_final : head_span[SW-1:0];
        cur_ok = clip ? (r_cur <= r_final) : ({1'b0, r_cur} <= head_span);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_end <= '0;
            r_final <= '0;
            r_peer <= '0;
            r_dup <= '0;
            r_to_cnt <= '0;
            r_active <= 1'b0;
            r_stat_pend <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_stat_pend <= is_timeout && abort_now;
                r_stat_kind <= is_timeout ? sws_pkg::KIND_ABORT : sws_pkg::KIND_COMPLETE;
                r_supp <= 1'b0;
                if (is_start) begin
                    r_head <= sum_head;
                    r_final <= sum_fin;
                    r_peer <= r_in.seq_number;
                    r_dup <= '0;
                    r_to_cnt <= '0;
                    r_active <= !start_empty;
                    r_cur <= sum_head;
                end else if (is_packet) begin
                    r_peer <= r_in.seq_number;
                    r_to_cnt <= '0;
                    if (plain_ack) begin
                        if (in_win) begin
                            r_dup <= '0;
                            r_head <= sum_head;
                            r_active <= !slide_done;
                            r_cur <= r_end + 32'd1;
                            // Nothing new to send when the old end sits at the top.
                            r_supp <= (r_end == SEQ_MAX);
                        end else if (is_dup) begin
                            r_dup <= dup_fire ? 2'd0 : dup_n;
                            r_cur <= r_head;
                        end
                    end
                end else if (is_timeout) begin
                    r_cur <= r_head;
                    if (abort_now) begin
                        r_active <= 1'b0;
                    end else begin
                        r_to_cnt <= r_to_cnt + 3'd1;
                    end
                end
            end
            if (i_cmd.send) begin
                r_cur <= r_cur + 32'd1;
            end
            if (i_cmd.limit) begin
                r_end <= lim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.limit) begin
            r_to <= lim;
        end
    end

    // Output register: the controller loads it only when it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.send || i_cmd.stat) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send) begin
            r_out.kind <= sws_pkg::KIND_SEND;
            r_out.send_seq <= r_cur;
            r_out.send_ack <= r_peer;
            r_out.last <= (r_cur == r_to) && !r_stat_pend;
        end else if (i_cmd.stat) begin
            r_out.kind <= r_stat_kind;
            r_out.send_seq <= '0;
            r_out.send_ack <= '0;
            r_out.last <= 1'b1;
        end
    end

    always_comb begin
        o_sts.ev_limit = ev_limit;
        o_sts.ev_stat = ev_stat;
        o_sts.nonempty = !r_supp && cur_ok;
        o_sts.at_end = (r_cur == r_to);
        o_sts.stat_pend = r_stat_pend;
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

`ifndef SYNTHESIS
    // While a transfer runs and the block is idle the window lies in order.
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && i_cmd.load_in) |-> ((r_head <= r_end) && (r_end <= r_final)))
        else $error("window bounds out of order");

    // The send cursor never runs past the end of its range.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.send |-> (r_cur <= r_to))
        else $error("send cursor beyond range end");

    // The timeout run never grows beyond one above its limit.
    a_timeout_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_to_cnt <= 3'(sws_pkg::TIMEOUT_LIMIT + 1))
        else $error("timeout run overflow");

    // A status result is always the final result of its transaction.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.stat |=> (r_out.last && (r_out.kind != sws_pkg::KIND_SEND)))
        else $error("status result not marked last");
`endif

endmodule

`default_nettype wire

>>> design/sliding_window_sender_unit.sv
// The first result is registered after acceptance via EVAL, LIMIT and SEND (EVAL and STAT
// for a lone status result), then one result per cycle while the output is not stalled.
// Up to WINDOW sends plus a status result per transaction, set by the single send cursor;
// one without results passes EVAL, or EVAL and LIMIT when a window is recomputed.
// Output stall stretches the send phase. Reset is synchronous, active low: window state,
// counters and packet_count clear to zero.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_sender_unit #(
    parameter int WINDOW = sws_pkg::WINDOW_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire sws_pkg::t_in                  i_in_data,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output sws_pkg::t_out                      o_out_data,
    input  wire logic                          i_out_stall,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sws_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [sws_pkg::PDATA_W-1:0]   pwdata,
    output logic [sws_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    logic [sws_pkg::PCNT_W-1:0] r_pkt_count;
    sws_pkg::t_cmd              cmd;
    sws_pkg::t_sts              sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_count <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == sws_pkg::REG_PACKET_COUNT)) begin
            r_pkt_count <= pwdata[sws_pkg::PCNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == sws_pkg::REG_PACKET_COUNT) begin
            prdata = sws_pkg::PDATA_W'(r_pkt_count);
        end
    end

    sws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sws_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_pkt_count (r_pkt_count),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
